@@ hdl/multichannel_peak_meter_top_defines.svh @@
// Assertion macros for the multichannel peak meter.
// Included by the top level only; no other dependencies.
`ifndef MULTICHANNEL_PEAK_METER_TOP_DEFINES_SVH
`define MULTICHANNEL_PEAK_METER_TOP_DEFINES_SVH
`ifndef SYNTH
`define MPM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define MPM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define MPM_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define MPM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ hdl/mpm_pkg.sv @@
// Shared types, codes, constants and the log mapping table of the peak meter.
// No dependencies.
`default_nettype none
package mpm_pkg;

  localparam int MAX_CHANNELS      = 8;
  localparam int LOG_TABLE_ENTRIES = 256;
  localparam int OUT_LIMIT         = 8;
  localparam int ACTIVE_LIMIT      = (MAX_CHANNELS < OUT_LIMIT) ? MAX_CHANNELS : OUT_LIMIT;
  localparam int CH_IDX_W          = (ACTIVE_LIMIT > 1) ? $clog2(ACTIVE_LIMIT) : 1;
  localparam int LOG_SPAN          = LOG_TABLE_ENTRIES - 1;
  localparam int LUT_IDX_W         = $clog2(LOG_TABLE_ENTRIES);
  localparam int LUT_PROD_W        = 16 + LUT_IDX_W + 1;
  localparam logic [63:0] LOG10_2_Q32 = 64'd1292913986;

  localparam logic [3:0]  RST_CHANNEL_COUNT = 4'd2;
  localparam logic        RST_LOG_MODE      = 1'b1;
  localparam logic [15:0] RST_DECAY_STEP    = 16'd328;

  typedef enum logic [1:0] {
    MODE_SAMPLE   = 2'd0,
    MODE_SNAPSHOT = 2'd1,
    MODE_DISPLAY  = 2'd2,
    MODE_NONE     = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REG_CHANNEL_COUNT = 2'd0,
    REG_LOG_MODE      = 2'd1,
    REG_DECAY_STEP    = 2'd2,
    REG_UNUSED        = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DISP = 2'b10
  } state_t;

  typedef struct packed {
    logic accept;
    logic burst_start;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic last_ch;
  } stat_t;

  typedef logic [LOG_TABLE_ENTRIES-1:0][15:0] lut_t;

  function automatic lut_t build_lut();
    lut_t t;
    logic [63:0] y;
    logic [63:0] ip;
    logic [63:0] k;
    logic [63:0] m;
    logic [63:0] frac;
    logic [63:0] lg;
    logic [63:0] v;
    for (int i = 0; i < LOG_TABLE_ENTRIES; i++) begin
      y = ((64'(LOG_SPAN) + 64'(9 * i)) << 28) / 64'(LOG_SPAN);
      ip = y >> 28;
      k = 64'd0;
      for (int j = 0; j < 3; j++) begin
        if ((ip >> (j + 1)) != 64'd0) k = 64'(j + 1);
      end
      m = y >> k;
      frac = 64'd0;
      for (int b = 0; b < 20; b++) begin
        m = (m * m) >> 28;
        frac = frac << 1;
        if (m >= (64'd2 << 28)) begin
          m = m >> 1;
          frac = frac | 64'd1;
        end
      end
      lg = (k << 20) | frac;
      v = (lg * LOG10_2_Q32 + (64'd1 << 35)) >> 36;
      t[i] = (v > 64'd65535) ? 16'hFFFF : v[15:0];
    end
    return t;
  endfunction

  localparam lut_t LOG_LUT = build_lut();

endpackage
`default_nettype wire

@@ hdl/mpm_ctrl.sv @@
// Controller of the peak meter: idle and display-burst states.
// Depends on mpm_pkg; drives commands to mpm_datapath and reads its status.
`default_nettype none
module mpm_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic [1:0]    in_mode,
  output logic               in_stall,
  input  wire mpm_pkg::stat_t stat,
  output mpm_pkg::cmd_t      cmd
);

  mpm_pkg::state_t state_r;
  mpm_pkg::state_t state_nxt;

  always_comb begin
    state_nxt       = state_r;
    cmd.accept      = 1'b0;
    cmd.burst_start = 1'b0;
    cmd.emit        = 1'b0;
    in_stall        = 1'b1;
    case (state_r)
      mpm_pkg::S_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
        if (in_valid && (in_mode == mpm_pkg::MODE_DISPLAY)) begin
          cmd.burst_start = 1'b1;
          state_nxt       = mpm_pkg::S_DISP;
        end
      end
      mpm_pkg::S_DISP: begin
        cmd.emit = stat.out_free;
        if (stat.out_free && stat.last_ch) state_nxt = mpm_pkg::S_IDLE;
      end
      default: begin
        state_nxt = mpm_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mpm_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

@@ hdl/mpm_datapath.sv @@
// Datapath of the peak meter: configuration, per-channel stores, level mapping
// and the output register. Depends on mpm_pkg; steered by mpm_ctrl.
`default_nettype none
module mpm_datapath (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_valid,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [15:0]        cfg_data,
  input  wire logic [1:0]         in_mode,
  input  wire logic [2:0]         in_channel,
  input  wire logic signed [15:0] in_sample,
  input  wire mpm_pkg::cmd_t      cmd,
  output mpm_pkg::stat_t          stat,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [2:0]              out_channel,
  output logic [15:0]             out_level,
  output logic                    out_last
);

  logic [3:0]  cfg_count_r;
  logic        cfg_log_r;
  logic [15:0] cfg_decay_r;

  logic [15:0] peak_r  [mpm_pkg::ACTIVE_LIMIT];
  logic [15:0] snap_r  [mpm_pkg::ACTIVE_LIMIT];
  logic [15:0] shown_r [mpm_pkg::ACTIVE_LIMIT];
  logic        pending_r;
  logic [mpm_pkg::CH_IDX_W-1:0] cnt_r;
  logic        out_valid_r;
  logic [2:0]  out_channel_r;
  logic [15:0] out_level_r;
  logic        out_last_r;

  logic [3:0]  n_act;
  logic        ch_ok;
  logic [mpm_pkg::CH_IDX_W-1:0] ch_idx;
  logic [15:0] mag;
  logic [15:0] snap_cur;
  logic [15:0] shown_cur;
  logic [mpm_pkg::LUT_PROD_W-1:0] prod;
  logic [mpm_pkg::LUT_PROD_W-1:0] idx_full;
  logic [mpm_pkg::LUT_IDX_W-1:0] lut_idx;
  logic [16:0] lin2;
  logic [15:0] map_lvl;
  logic [15:0] decay_lvl;
  logic [15:0] lvl;

  always_comb begin
    n_act = cfg_count_r;
    if (n_act == 4'd0) n_act = 4'd1;
    if (n_act > 4'(mpm_pkg::ACTIVE_LIMIT)) n_act = 4'(mpm_pkg::ACTIVE_LIMIT);
  end

  assign ch_ok  = ({1'b0, in_channel} < n_act);
  assign ch_idx = mpm_pkg::CH_IDX_W'(in_channel);
  assign mag    = in_sample[15] ? (~in_sample + 16'd1) : in_sample;

  assign snap_cur  = snap_r[cnt_r];
  assign shown_cur = shown_r[cnt_r];
  assign prod      = mpm_pkg::LUT_PROD_W'(snap_cur) *
                     mpm_pkg::LUT_PROD_W'(mpm_pkg::LOG_SPAN);
  assign idx_full  = (prod + mpm_pkg::LUT_PROD_W'(16384)) >> 15;
  assign lut_idx   = (idx_full > mpm_pkg::LUT_PROD_W'(mpm_pkg::LOG_SPAN)) ?
                     mpm_pkg::LUT_IDX_W'(mpm_pkg::LOG_SPAN) :
                     idx_full[mpm_pkg::LUT_IDX_W-1:0];
  assign lin2      = {snap_cur, 1'b0};
  assign map_lvl   = cfg_log_r ? mpm_pkg::LOG_LUT[lut_idx] :
                     (lin2[16] ? 16'hFFFF : lin2[15:0]);
  assign decay_lvl = (shown_cur > cfg_decay_r) ? (shown_cur - cfg_decay_r) : 16'd0;
  assign lvl       = pending_r ? map_lvl : decay_lvl;

  assign stat = '{out_free: (!out_valid_r || !out_stall),
                  last_ch:  (4'(cnt_r) == (n_act - 4'd1))};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_count_r <= mpm_pkg::RST_CHANNEL_COUNT;
      cfg_log_r   <= mpm_pkg::RST_LOG_MODE;
      cfg_decay_r <= mpm_pkg::RST_DECAY_STEP;
      for (int i = 0; i < mpm_pkg::ACTIVE_LIMIT; i++) begin
        peak_r[i]  <= 16'd0;
        snap_r[i]  <= 16'd0;
        shown_r[i] <= 16'd0;
      end
      pending_r   <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          mpm_pkg::REG_CHANNEL_COUNT: cfg_count_r <= cfg_data[3:0];
          mpm_pkg::REG_LOG_MODE:      cfg_log_r   <= cfg_data[0];
          mpm_pkg::REG_DECAY_STEP:    cfg_decay_r <= cfg_data;
          default: begin
          end
        endcase
      end
      if (cmd.accept && (in_mode == mpm_pkg::MODE_SAMPLE) && ch_ok &&
          (mag > peak_r[ch_idx])) begin
        peak_r[ch_idx] <= mag;
      end
      if (cmd.accept && (in_mode == mpm_pkg::MODE_SNAPSHOT)) begin
        for (int i = 0; i < mpm_pkg::ACTIVE_LIMIT; i++) begin
          snap_r[i] <= peak_r[i];
          peak_r[i] <= 16'd0;
        end
        pending_r <= 1'b1;
      end
      if (cmd.burst_start) cnt_r <= '0;
      if (cmd.emit) begin
        shown_r[cnt_r] <= lvl;
        cnt_r          <= cnt_r + 1'b1;
        if (stat.last_ch) pending_r <= 1'b0;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_channel_r <= 3'(cnt_r);
      out_level_r   <= lvl;
      out_last_r    <= stat.last_ch;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_channel = out_channel_r;
  assign out_level   = out_level_r;
  assign out_last    = out_last_r;

endmodule
`default_nettype wire

@@ hdl/multichannel_peak_meter_top.sv @@
// Multichannel peak meter. Sample and snapshot words are accepted without stalling.
// A display word moves the controller to its display state, which stalls the input
// while the levels of the active channels leave through the output register, one per
// cycle unless out_stall holds them, paced by the single shared level-mapping path.
// Synchronous active-low reset restores the register defaults and clears all
// peaks, snapshots, shown levels and the pending mark at once.
`default_nettype none
`include "multichannel_peak_meter_top_defines.svh"
module multichannel_peak_meter_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [15:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         in_mode,
  input  wire logic [2:0]         in_channel,
  input  wire logic signed [15:0] in_sample,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [2:0]              out_channel,
  output logic [15:0]             out_level,
  output logic                    out_last
);

  mpm_pkg::cmd_t  cmd;
  mpm_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  mpm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_mode),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  mpm_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_mode     (in_mode),
    .in_channel  (in_channel),
    .in_sample   (in_sample),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_channel (out_channel),
    .out_level   (out_level),
    .out_last    (out_last)
  );

  `MPM_ASSERT_SAME(a_no_accept_in_burst, clk, rst_n, cmd.emit, !cmd.accept && in_stall)
  `MPM_ASSERT_NEXT(a_burst_blocks_input, clk, rst_n, cmd.burst_start, in_stall)
  `MPM_ASSERT_NEXT(a_emit_shows_word, clk, rst_n, cmd.emit, out_valid)
  `MPM_ASSERT_SAME(a_mid_burst_stalls, clk, rst_n, out_valid && !out_stall && !out_last,
                   in_stall)

endmodule
`default_nettype wire

@@ sim/mpm_checker.sv @@
`timescale 1ns / 1ps
// Checker for the multichannel peak meter: watches the register, input and level channels,
// keeps its own copy of the meter state and compares every level word it sees.
// Depends on mpm_pkg for the mode and register codes and the table size.
module mpm_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [1:0]  in_mode,
  input  wire logic [2:0]  in_channel,
  input  wire logic [15:0] in_sample,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [2:0]  out_channel,
  input  wire logic [15:0] out_level,
  input  wire logic        out_last,
  output int unsigned      err_count,
  output int unsigned      due_count,
  output int unsigned      levels_seen
);

  typedef struct packed {
    logic [2:0]  channel;
    logic [15:0] level;
    logic        last;
  } level_word_t;

  level_word_t level_q[$];
  logic [15:0] log_tab [mpm_pkg::LOG_TABLE_ENTRIES];
  logic [15:0] peak [mpm_pkg::MAX_CHANNELS];
  logic [15:0] snap [mpm_pkg::MAX_CHANNELS];
  logic [15:0] shown [mpm_pkg::MAX_CHANNELS];
  logic        pend;
  logic [3:0]  cc;
  logic        lm;
  logic [15:0] ds;
  int unsigned n_err = 0;
  int unsigned n_seen = 0;

  function automatic logic [15:0] log_level(int unsigned idx);
    logic [63:0] y;
    logic [63:0] m;
    logic [63:0] frac;
    logic [63:0] lg;
    logic [63:0] v;
    int unsigned k;
    y = ((64'(mpm_pkg::LOG_TABLE_ENTRIES - 1) + 64'(9 * idx)) << 28) /
        64'(mpm_pkg::LOG_TABLE_ENTRIES - 1);
    k = 0;
    while (k < 3 && (y >> (28 + k + 1)) != 64'd0) k++;
    m = y >> k;
    frac = 64'd0;
    repeat (20) begin
      m = (m * m) >> 28;
      frac = {frac[62:0], 1'b0};
      if (m >= (64'd2 << 28)) begin
        m = m >> 1;
        frac[0] = 1'b1;
      end
    end
    lg = (64'(k) << 20) | frac;
    v = (lg * mpm_pkg::LOG10_2_Q32 + (64'd1 << 35)) >> 36;
    return (v > 64'd65535) ? 16'hFFFF : v[15:0];
  endfunction

  initial begin
    for (int i = 0; i < mpm_pkg::LOG_TABLE_ENTRIES; i++) log_tab[i] = log_level(i);
  end

  function automatic int unsigned active_count(logic [3:0] c);
    int unsigned n;
    n = (c == 4'd0) ? 1 : int'(c);
    if (n > mpm_pkg::MAX_CHANNELS) n = mpm_pkg::MAX_CHANNELS;
    if (n > mpm_pkg::OUT_LIMIT) n = mpm_pkg::OUT_LIMIT;
    return n;
  endfunction

  function automatic logic [15:0] map_level(logic [15:0] p);
    logic [31:0] idx;
    logic [16:0] dbl;
    if (lm) begin
      idx = (32'(p) * 32'(mpm_pkg::LOG_SPAN) + 32'd16384) >> 15;
      if (idx > 32'(mpm_pkg::LOG_SPAN)) idx = 32'(mpm_pkg::LOG_SPAN);
      return log_tab[idx[mpm_pkg::LUT_IDX_W-1:0]];
    end
    dbl = {1'b0, p} << 1;
    return (dbl > 17'd65535) ? 16'hFFFF : dbl[15:0];
  endfunction

  task automatic update_meter(logic [1:0] mode, logic [2:0] ch, logic [15:0] raw);
    int unsigned n;
    logic [16:0] mag;
    level_word_t w;
    n = active_count(cc);
    case (mpm_pkg::mode_t'(mode))
      mpm_pkg::MODE_SAMPLE: begin
        mag = raw[15] ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
        if (ch < n && mag > {1'b0, peak[ch]}) peak[ch] = mag[15:0];
      end
      mpm_pkg::MODE_SNAPSHOT: begin
        for (int c = 0; c < mpm_pkg::MAX_CHANNELS; c++) begin
          snap[c] = peak[c];
          peak[c] = 16'd0;
        end
        pend = 1'b1;
      end
      mpm_pkg::MODE_DISPLAY: begin
        for (int c = 0; c < n; c++) begin
          if (pend) shown[c] = map_level(snap[c]);
          else shown[c] = (shown[c] > ds) ? shown[c] - ds : 16'd0;
          w.channel = 3'(c);
          w.level   = shown[c];
          w.last    = (c + 1 == n);
          level_q.insert(level_q.size(), w);
        end
        pend = 1'b0;
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk) begin : watch
    level_word_t got;
    level_word_t want;
    if (!rst_n) begin
      for (int c = 0; c < mpm_pkg::MAX_CHANNELS; c++) begin
        peak[c]  = 16'd0;
        snap[c]  = 16'd0;
        shown[c] = 16'd0;
      end
      pend = 1'b0;
      cc = mpm_pkg::RST_CHANNEL_COUNT;
      lm = mpm_pkg::RST_LOG_MODE;
      ds = mpm_pkg::RST_DECAY_STEP;
      level_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = '{out_channel, out_level, out_last};
        if (level_q.size() == 0) begin
          n_err++;
          $display("%0t: level word with none expected: channel %0d level %0d last %0d",
                   $time, got.channel, got.level, got.last);
        end else begin
          want = level_q.pop_front();
          n_seen++;
          if (got.channel !== want.channel)
            $display("%0t: channel expected %0d, actual %0d", $time, want.channel, got.channel);
          if (got.level !== want.level)
            $display("%0t: level on channel %0d expected %0d, actual %0d",
                     $time, want.channel, want.level, got.level);
          if (got.last !== want.last)
            $display("%0t: last on channel %0d expected %0d, actual %0d",
                     $time, want.channel, want.last, got.last);
          if (got !== want) n_err++;
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (mpm_pkg::reg_idx_t'(cfg_index))
          mpm_pkg::REG_CHANNEL_COUNT: cc = cfg_data[3:0];
          mpm_pkg::REG_LOG_MODE:      lm = cfg_data[0];
          mpm_pkg::REG_DECAY_STEP:    ds = cfg_data;
          default: begin
          end
        endcase
      end
      if (in_valid && !in_stall) update_meter(in_mode, in_channel, in_sample);
    end
    err_count   <= n_err;
    due_count   <= level_q.size();
    levels_seen <= n_seen;
  end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench top for the multichannel peak meter: clock, reset, register writes,
// sample/snapshot/display words and level-channel stalls; the verdict comes from mpm_checker.
// Depends on mpm_pkg, mpm_checker and multichannel_peak_meter_top.
module tb_top;

  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned SETTLE_CYCLES  = 12;
  localparam int unsigned PHASES         = 8;
  localparam int unsigned PHASE_WORDS    = 18;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = 2'd0;
  logic [15:0] cfg_data = 16'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_mode = 2'd0;
  logic [2:0]  in_channel = 3'd0;
  logic [15:0] in_sample = 16'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_channel;
  logic [15:0] out_level;
  logic        out_last;

  int unsigned err_count;
  int unsigned due_count;
  int unsigned levels_seen;
  int unsigned words_sent = 0;
  int unsigned regs_written = 0;
  int unsigned idle_cycles = 0;
  int unsigned stall_left = 0;
  int unsigned active_n = 2;
  logic        steady = 1'b0;

  multichannel_peak_meter_top i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_mode     (in_mode),
    .in_channel  (in_channel),
    .in_sample   (in_sample),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_channel (out_channel),
    .out_level   (out_level),
    .out_last    (out_last)
  );

  mpm_checker i_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_mode     (in_mode),
    .in_channel  (in_channel),
    .in_sample   (in_sample),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_channel (out_channel),
    .out_level   (out_level),
    .out_last    (out_last),
    .err_count   (err_count),
    .due_count   (due_count),
    .levels_seen (levels_seen)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no word moved for %0d cycles.", idle_cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin : stall_gen
    int unsigned r;
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        out_stall <= 1'b0;
        stall_left <= $urandom_range(0, 20);
      end else if (r < 85) begin
        out_stall <= 1'b1;
        stall_left <= $urandom_range(0, 3);
      end else if (r < 95) begin
        out_stall <= 1'b0;
        stall_left <= $urandom_range(40, 100);
      end else begin
        out_stall <= 1'b1;
        stall_left <= $urandom_range(15, 50);
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [15:0] pick_sample();
    int unsigned r;
    logic [15:0] v;
    r = $urandom_range(0, 99);
    if (r < 8) v = 16'h8000;
    else if (r < 16) v = 16'h7FFF;
    else if (r < 22) v = 16'hFFFF;
    else if (r < 55) v = 16'($urandom);
    else begin
      v = 16'($urandom_range(0, 3000));
      if ($urandom_range(0, 1) == 1) v = -v;
    end
    return v;
  endfunction

  function automatic logic [2:0] pick_channel();
    if ($urandom_range(0, 99) < 85) return 3'($urandom_range(0, active_n - 1));
    return 3'($urandom_range(0, 7));
  endfunction

  task automatic send_word(mpm_pkg::mode_t mode, logic [2:0] ch, logic [15:0] smp);
    int unsigned gap;
    in_valid   <= 1'b1;
    in_mode    <= mode;
    in_channel <= ch;
    in_sample  <= smp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (due_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(mpm_pkg::reg_idx_t idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    regs_written++;
    if (idx == mpm_pkg::REG_CHANNEL_COUNT) begin
      active_n = (data[3:0] == 4'd0) ? 1 : int'(data[3:0]);
      if (active_n > mpm_pkg::MAX_CHANNELS) active_n = mpm_pkg::MAX_CHANNELS;
    end
    @(posedge clk);
  endtask

  task automatic random_phase(int unsigned target);
    int unsigned start;
    start = words_sent;
    steady = ($urandom_range(0, 3) == 0);
    while (words_sent - start < target) begin
      if ($urandom_range(0, 99) < 75) begin
        repeat ($urandom_range(1, 2 * active_n + 2))
          send_word(mpm_pkg::MODE_SAMPLE, pick_channel(), pick_sample());
        send_word(mpm_pkg::MODE_SNAPSHOT, 3'($urandom), 16'($urandom));
        repeat ($urandom_range(1, 3))
          send_word(mpm_pkg::MODE_DISPLAY, 3'($urandom), 16'($urandom));
      end else begin
        case ($urandom_range(0, 3))
          0: send_word(mpm_pkg::MODE_NONE, 3'($urandom), 16'($urandom));
          1: send_word(mpm_pkg::MODE_DISPLAY, 3'($urandom), 16'($urandom));
          2: send_word(mpm_pkg::MODE_SNAPSHOT, 3'($urandom), 16'($urandom));
          default: send_word(mpm_pkg::MODE_SAMPLE, 3'($urandom_range(0, 7)), pick_sample());
        endcase
      end
    end
    steady = 1'b0;
  endtask

  initial begin : stimulus
    logic [3:0]  cc;
    logic [15:0] ds;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: display before any snapshot, extremes, inactive channels, mode 3.
    send_word(mpm_pkg::MODE_DISPLAY, 3'd0, 16'd0);
    send_word(mpm_pkg::MODE_SAMPLE, 3'd0, 16'h7FFF);
    send_word(mpm_pkg::MODE_SAMPLE, 3'd1, 16'h8000);
    send_word(mpm_pkg::MODE_SAMPLE, 3'd0, 16'hFFFF);
    send_word(mpm_pkg::MODE_SAMPLE, 3'd2, 16'h8000);
    send_word(mpm_pkg::MODE_SAMPLE, 3'd7, 16'h7FFF);
    send_word(mpm_pkg::MODE_NONE, 3'd7, 16'hFFFF);
    send_word(mpm_pkg::MODE_SNAPSHOT, 3'd0, 16'd0);
    send_word(mpm_pkg::MODE_DISPLAY, 3'd0, 16'd0);
    send_word(mpm_pkg::MODE_DISPLAY, 3'd0, 16'd0);
    send_word(mpm_pkg::MODE_SNAPSHOT, 3'd0, 16'd0);
    send_word(mpm_pkg::MODE_DISPLAY, 3'd0, 16'd0);
    settle();

    write_reg(mpm_pkg::REG_CHANNEL_COUNT, 16'd8);
    write_reg(mpm_pkg::REG_LOG_MODE, 16'd0);
    write_reg(mpm_pkg::REG_DECAY_STEP, 16'hFFFF);
    write_reg(mpm_pkg::REG_UNUSED, 16'hFFFF);
    send_word(mpm_pkg::MODE_SAMPLE, 3'd0, 16'h7FFF);
    send_word(mpm_pkg::MODE_SAMPLE, 3'd1, 16'h8000);
    send_word(mpm_pkg::MODE_SAMPLE, 3'd2, 16'h0001);
    send_word(mpm_pkg::MODE_SAMPLE, 3'd3, 16'hFFFF);
    send_word(mpm_pkg::MODE_SAMPLE, 3'd4, 16'h5555);
    send_word(mpm_pkg::MODE_SAMPLE, 3'd5, 16'hAAAA);
    send_word(mpm_pkg::MODE_SAMPLE, 3'd6, 16'h0000);
    send_word(mpm_pkg::MODE_SAMPLE, 3'd7, 16'h4000);
    send_word(mpm_pkg::MODE_SNAPSHOT, 3'd0, 16'd0);
    send_word(mpm_pkg::MODE_DISPLAY, 3'd0, 16'd0);
    send_word(mpm_pkg::MODE_DISPLAY, 3'd0, 16'd0);
    settle();

    for (int unsigned i = 0; i < PHASES; i++) begin
      case (i)
        0: cc = 4'd1;
        1: cc = 4'd8;
        2: cc = 4'd0;
        3: cc = 4'd15;
        4: cc = 4'd3;
        6: cc = 4'd5;
        default: cc = 4'($urandom);
      endcase
      case (i % 4)
        0: ds = 16'd0;
        1: ds = 16'hFFFF;
        2: ds = 16'($urandom_range(1, 3000));
        default: ds = 16'($urandom);
      endcase
      settle();
      write_reg(mpm_pkg::REG_CHANNEL_COUNT, {12'($urandom), cc});
      write_reg(mpm_pkg::REG_LOG_MODE, {15'($urandom), i[0]});
      write_reg(mpm_pkg::REG_DECAY_STEP, ds);
      if (i[0]) write_reg(mpm_pkg::REG_UNUSED, 16'($urandom));
      random_phase(PHASE_WORDS);
    end
    settle();

    $display("Sent %0d input words across %0d register writes and compared %0d levels,",
             words_sent, regs_written, levels_seen);
    $display("covering log and linear mapping, decay extremes and channel counts 0 to 15.");
    if (err_count == 0 && due_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ multichannel_peak_meter_top.f @@
+incdir+hdl
hdl/mpm_pkg.sv
hdl/mpm_ctrl.sv
hdl/mpm_datapath.sv
hdl/multichannel_peak_meter_top.sv
sim/mpm_checker.sv
sim/tb_top.sv
